[hdl/hsl2rgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hsl2rgb_pkg;

	// unsigned fixed point, 16 fractional bits, range 0..1.0
	typedef logic [16:0] fx_t;

	localparam fx_t FX_ONE        = 17'd65536;
	localparam fx_t FX_THIRD      = 17'd21845;
	localparam fx_t FX_SIXTH      = 17'd10922;
	localparam fx_t FX_HALF       = 17'd32768;
	localparam fx_t FX_TWO_THIRDS = 17'd43690;

	localparam logic [8:0] HUE_MAX = 9'd360;
	localparam logic [6:0] PCT_MAX = 7'd100;

	// floor(hue * 65536 / 360) == (hue * HUE_RECIP) >> 15 for hue <= 360
	localparam logic [22:0] HUE_RECIP = 23'd5965233;
	// floor(pct * 65536 / 100) == (pct * PCT_RECIP) >> 12 for pct <= 100
	localparam logic [21:0] PCT_RECIP = 22'd2684355;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	typedef struct packed {
		fx_t p;
		fx_t q;
		fx_t d;
	} ramp_setup_t;

	typedef struct packed {
		fx_t  t;
		seg_t seg;
	} chan_pos_t;

endpackage

`default_nettype wire

[hdl/hsl_to_rgb_converter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB converter. Takes hue in degrees (clamped to 360) and saturation and
// lightness in percent (clamped to 100) and returns 8-bit red, green and blue
// using the standard HSL formula in 16-bit-fraction fixed point, truncating at
// every step. The block is a six-stage pipeline: a color is taken on every clock
// where start is high, busy is always low, and the result appears on red, green
// and blue at the end of the pipeline with done high for a single cycle. The
// pipeline never stalls, so the receiver must take every result as it comes.
// There is no state across colors and no configuration.

module hsl_to_rgb_converter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [8:0]  hue,
	input  wire logic [6:0]  saturation,
	input  wire logic [6:0]  lightness,
	output      logic        done,
	output      logic [7:0]  red,
	output      logic [7:0]  green,
	output      logic [7:0]  blue
);

	logic                     valid_s3;
	logic                     valid_s4, valid_s5, valid_s6;
	hsl2rgb_pkg::ramp_setup_t setup;
	hsl2rgb_pkg::chan_pos_t   pos_r, pos_g, pos_b;

	assign busy = 1'b0;

	hsl2rgb_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.out_valid  (valid_s3),
		.setup      (setup),
		.pos_r      (pos_r),
		.pos_g      (pos_g),
		.pos_b      (pos_b)
	);

	hsl2rgb_chan u_chan_r (
		.clk   (clk),
		.setup (setup),
		.pos   (pos_r),
		.level (red)
	);

	hsl2rgb_chan u_chan_g (
		.clk   (clk),
		.setup (setup),
		.pos   (pos_g),
		.level (green)
	);

	hsl2rgb_chan u_chan_b (
		.clk   (clk),
		.setup (setup),
		.pos   (pos_b),
		.level (blue)
	);

	// transaction valid follows the channel stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign done = valid_s6;

endmodule

`default_nettype wire

[hdl/hsl2rgb_norm.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_norm (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [8:0]                hue,
	input  wire logic [6:0]                saturation,
	input  wire logic [6:0]                lightness,
	output      logic                      out_valid,
	output      hsl2rgb_pkg::ramp_setup_t  setup,
	output      hsl2rgb_pkg::chan_pos_t    pos_r,
	output      hsl2rgb_pkg::chan_pos_t    pos_g,
	output      hsl2rgb_pkg::chan_pos_t    pos_b
);

	logic                valid_s1, valid_s2, valid_s3;
	logic [8:0]          hue_c;
	logic [6:0]          sat_c, lit_c;
	logic [31:0]         h_prod;
	logic [28:0]         s_prod, l_prod;
	hsl2rgb_pkg::fx_t    h_s1, s_s1, l_s1;

	logic [33:0]         ls_prod;
	logic [17:0]         tr_sum;
	hsl2rgb_pkg::fx_t    tr, tb;
	hsl2rgb_pkg::fx_t    ls_s2, s_s2, l_s2;
	hsl2rgb_pkg::chan_pos_t pos_r_s2, pos_g_s2, pos_b_s2;

	logic [17:0]         q_w, two_l;
	hsl2rgb_pkg::fx_t    q_c, p_c;
	hsl2rgb_pkg::ramp_setup_t setup_s3;
	hsl2rgb_pkg::chan_pos_t   pos_r_s3, pos_g_s3, pos_b_s3;

	function automatic hsl2rgb_pkg::seg_t seg_of(input hsl2rgb_pkg::fx_t t);
		hsl2rgb_pkg::seg_t s;
		if (t < hsl2rgb_pkg::FX_SIXTH)
			s = hsl2rgb_pkg::SEG_RISE;
		else if (t < hsl2rgb_pkg::FX_HALF)
			s = hsl2rgb_pkg::SEG_HIGH;
		else if (t < hsl2rgb_pkg::FX_TWO_THIRDS)
			s = hsl2rgb_pkg::SEG_FALL;
		else
			s = hsl2rgb_pkg::SEG_LOW;
		return s;
	endfunction

	// stage 1: clamp and scale to fixed point
	always_comb begin
		hue_c  = (hue > hsl2rgb_pkg::HUE_MAX) ? hsl2rgb_pkg::HUE_MAX : hue;
		sat_c  = (saturation > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : saturation;
		lit_c  = (lightness > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : lightness;
		h_prod = {23'd0, hue_c} * {9'd0, hsl2rgb_pkg::HUE_RECIP};
		s_prod = {22'd0, sat_c} * {7'd0, hsl2rgb_pkg::PCT_RECIP};
		l_prod = {22'd0, lit_c} * {7'd0, hsl2rgb_pkg::PCT_RECIP};
	end

	always_ff @(posedge clk) begin
		h_s1 <= h_prod[31:15];
		s_s1 <= s_prod[28:12];
		l_s1 <= l_prod[28:12];
	end

	// stage 2: l*s product and hue positions of the three channels
	always_comb begin
		ls_prod = {17'd0, l_s1} * {17'd0, s_s1};
		tr_sum  = {1'b0, h_s1} + {1'b0, hsl2rgb_pkg::FX_THIRD};
		if (tr_sum > {1'b0, hsl2rgb_pkg::FX_ONE})
			tr = 17'(tr_sum - {1'b0, hsl2rgb_pkg::FX_ONE});
		else
			tr = tr_sum[16:0];
		// negative position wraps up by one turn
		if (h_s1 < hsl2rgb_pkg::FX_THIRD)
			tb = h_s1 + (hsl2rgb_pkg::FX_ONE - hsl2rgb_pkg::FX_THIRD);
		else
			tb = h_s1 - hsl2rgb_pkg::FX_THIRD;
	end

	always_ff @(posedge clk) begin
		ls_s2        <= ls_prod[32:16];
		s_s2         <= s_s1;
		l_s2         <= l_s1;
		pos_r_s2.t   <= tr;
		pos_r_s2.seg <= seg_of(tr);
		pos_g_s2.t   <= h_s1;
		pos_g_s2.seg <= seg_of(h_s1);
		pos_b_s2.t   <= tb;
		pos_b_s2.seg <= seg_of(tb);
	end

	// stage 3: q, p and the ramp height; zero saturation gives p = q = l
	always_comb begin
		if (l_s2 < hsl2rgb_pkg::FX_HALF)
			q_w = {1'b0, l_s2} + {1'b0, ls_s2};
		else
			q_w = {1'b0, l_s2} + {1'b0, s_s2} - {1'b0, ls_s2};
		q_c   = q_w[16:0];
		two_l = {l_s2, 1'b0};
		if (two_l < q_w)
			p_c = '0;
		else
			p_c = 17'(two_l - q_w);
	end

	always_ff @(posedge clk) begin
		setup_s3.p <= p_c;
		setup_s3.q <= q_c;
		setup_s3.d <= q_c - p_c;
		pos_r_s3   <= pos_r_s2;
		pos_g_s3   <= pos_g_s2;
		pos_b_s3   <= pos_b_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign setup     = setup_s3;
	assign pos_r     = pos_r_s3;
	assign pos_g     = pos_g_s3;
	assign pos_b     = pos_b_s3;

endmodule

`default_nettype wire

[hdl/hsl2rgb_chan.sv]
`timescale 1ns / 1ps
`default_nettype none

module hsl2rgb_chan (
	input  wire logic                      clk,
	input  wire hsl2rgb_pkg::ramp_setup_t  setup,
	input  wire hsl2rgb_pkg::chan_pos_t    pos,
	output      logic [7:0]                level
);

	logic [13:0]              mul_op;
	logic [30:0]              prod_s4;
	hsl2rgb_pkg::seg_t        seg_s4;
	hsl2rgb_pkg::fx_t         p_s4, q_s4;

	logic [33:0]              prod6;
	logic [17:0]              v_c;
	logic [17:0]              v_s5;

	logic [25:0]              scaled;
	logic [7:0]               level_s6;

	// stage 4: one multiply, by t on the rising edge, by (2/3 - t) on the falling edge
	always_comb begin
		case (pos.seg)
			hsl2rgb_pkg::SEG_RISE: mul_op = pos.t[13:0];
			hsl2rgb_pkg::SEG_FALL: mul_op = 14'(hsl2rgb_pkg::FX_TWO_THIRDS - pos.t);
			default:               mul_op = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s4 <= {14'd0, setup.d} * {17'd0, mul_op};
		seg_s4  <= pos.seg;
		p_s4    <= setup.p;
		q_s4    <= setup.q;
	end

	// stage 5: ramp value; rise scales before the shift, fall after
	always_comb begin
		prod6 = {3'd0, prod_s4} * 34'd6;
		case (seg_s4)
			hsl2rgb_pkg::SEG_RISE: v_c = {1'b0, p_s4} + prod6[33:16];
			hsl2rgb_pkg::SEG_HIGH: v_c = {1'b0, q_s4};
			hsl2rgb_pkg::SEG_FALL: v_c = {1'b0, p_s4} + ({3'd0, prod_s4[30:16]} * 18'd6);
			default:               v_c = {1'b0, p_s4};
		endcase
	end

	always_ff @(posedge clk) begin
		v_s5 <= v_c;
	end

	// stage 6: times 255, truncate, saturate
	always_comb begin
		scaled = {v_s5, 8'd0} - {8'd0, v_s5};
	end

	always_ff @(posedge clk) begin
		level_s6 <= (scaled[25:16] > 10'd255) ? 8'd255 : scaled[23:16];
	end

	assign level = level_s6;

endmodule

`default_nettype wire

[dv/rgb_result_checker.sv]
`timescale 1ns / 1ps

module rgb_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [8:0] hue,
	input  logic [6:0] saturation,
	input  logic [6:0] lightness,
	input  logic       done,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output int         mismatches,
	output int         pending
);

	localparam longint ONE        = hsl2rgb_pkg::FX_ONE;
	localparam longint THIRD      = hsl2rgb_pkg::FX_THIRD;
	localparam longint SIXTH      = hsl2rgb_pkg::FX_SIXTH;
	localparam longint HALF       = hsl2rgb_pkg::FX_HALF;
	localparam longint TWO_THIRDS = hsl2rgb_pkg::FX_TWO_THIRDS;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] lit;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_txn_t;

	color_txn_t expected_colors[$];
	int         err_count;

	function automatic logic [7:0] fx_to_channel(input longint v);
		longint r;
		if (v < 0)
			v = 0;
		r = (v * 255) >> 16;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	// piecewise hue ramp, t wrapped into 0..1 first
	function automatic longint hue_ramp(input longint p, input longint q, input longint t);
		longint d;
		d = q - p;
		if (d < 0)
			d = 0;
		if (t < 0)
			t = t + ONE;
		if (t > ONE)
			t = t - ONE;
		if (t < SIXTH)
			return p + ((d * 6 * t) >> 16);
		if (t < HALF)
			return q;
		if (t < TWO_THIRDS)
			return p + (((d * (TWO_THIRDS - t)) >> 16) * 6);
		return p;
	endfunction

	function automatic color_txn_t rgb_from_hsl(input logic [8:0] hue_in,
			input logic [6:0] sat_in, input logic [6:0] lit_in);
		longint     hc, sc, lc, h, s, l, ls, q, p;
		color_txn_t c;
		c.hue = hue_in;
		c.sat = sat_in;
		c.lit = lit_in;
		hc = (hue_in > hsl2rgb_pkg::HUE_MAX) ? longint'(hsl2rgb_pkg::HUE_MAX)
			: longint'(hue_in);
		sc = (sat_in > hsl2rgb_pkg::PCT_MAX) ? longint'(hsl2rgb_pkg::PCT_MAX)
			: longint'(sat_in);
		lc = (lit_in > hsl2rgb_pkg::PCT_MAX) ? longint'(hsl2rgb_pkg::PCT_MAX)
			: longint'(lit_in);
		h = (hc << 16) / longint'(hsl2rgb_pkg::HUE_MAX);
		s = (sc << 16) / longint'(hsl2rgb_pkg::PCT_MAX);
		l = (lc << 16) / longint'(hsl2rgb_pkg::PCT_MAX);
		if (sc == 0) begin
			// grey
			c.red   = fx_to_channel(l);
			c.green = c.red;
			c.blue  = c.red;
			return c;
		end
		ls = (l * s) >> 16;
		if (l < HALF)
			q = l + ls;
		else
			q = l + s - ls;
		p = 2 * l - q;
		if (p < 0)
			p = 0;
		c.red   = fx_to_channel(hue_ramp(p, q, h + THIRD));
		c.green = fx_to_channel(hue_ramp(p, q, h));
		c.blue  = fx_to_channel(hue_ramp(p, q, h - THIRD));
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		color_txn_t exp_c;
		if (!arst_n) begin
			expected_colors.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_colors.size() == 0) begin
					if (err_count < 10)
						$display("%0t: result %0d %0d %0d with no transaction outstanding",
							$time, red, green, blue);
					err_count++;
				end else begin
					exp_c = expected_colors.pop_front();
					if (red !== exp_c.red || green !== exp_c.green || blue !== exp_c.blue)
					begin
						if (err_count < 10)
							$display("%0t: hsl %0d %0d %0d expected rgb %0d %0d %0d got %0d %0d %0d",
								$time, exp_c.hue, exp_c.sat, exp_c.lit,
								exp_c.red, exp_c.green, exp_c.blue, red, green, blue);
						err_count++;
					end
				end
			end
			if (start && !busy)
				expected_colors.push_back(rgb_from_hsl(hue, saturation, lightness));
			pending    <= expected_colors.size();
			mismatches <= err_count;
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [8:0] hue        = '0;
	logic [6:0] saturation = '0;
	logic [6:0] lightness  = '0;
	logic       busy;
	logic       done;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	int         mismatches;
	int         pending;
	int         idle_pct   = 0;

	hsl_to_rgb_converter_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	rgb_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// one transaction, then a random gap while the sender idles
	task automatic send_color(input logic [8:0] h, input logic [6:0] s, input logic [6:0] l);
		start      <= 1'b1;
		hue        <= h;
		saturation <= s;
		lightness  <= l;
		do @(posedge clk); while (busy);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start      <= 1'b0;
			hue        <= 9'($urandom);
			saturation <= 7'($urandom);
			lightness  <= 7'($urandom);
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_random_color();
		logic [8:0] h;
		logic [6:0] s;
		logic [6:0] l;
		h = 9'($urandom_range(360));
		s = 7'($urandom_range(100));
		l = 7'($urandom_range(100));
		case ($urandom_range(9))
			0: begin
				h = 9'($urandom);
				s = 7'($urandom);
				l = 7'($urandom);
			end
			1: s = 7'd0;
			2: h = 9'($urandom_range(511, 361));
			3: begin
				s = 7'($urandom_range(127, 101));
				l = 7'($urandom_range(127, 101));
			end
			default: ;
		endcase
		send_color(h, s, l);
	endtask

	initial begin
		int phase_idle[4];
		int wait_cycles;
		phase_idle = '{0, 74, 0, 29};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// primaries and secondaries around the hue circle
		send_color(9'd0, 7'd100, 7'd50);
		send_color(9'd60, 7'd100, 7'd50);
		send_color(9'd120, 7'd100, 7'd50);
		send_color(9'd180, 7'd100, 7'd50);
		send_color(9'd240, 7'd100, 7'd50);
		send_color(9'd300, 7'd100, 7'd50);
		send_color(9'd359, 7'd100, 7'd50);
		send_color(9'd360, 7'd100, 7'd50);
		// clamping of out-of-range fields
		send_color(9'd361, 7'd101, 7'd101);
		send_color(9'd511, 7'd127, 7'd127);
		send_color(9'd30, 7'd127, 7'd0);
		send_color(9'd0, 7'd127, 7'd0);
		send_color(9'd256, 7'd64, 7'd64);
		// grey
		send_color(9'd0, 7'd0, 7'd0);
		send_color(9'd0, 7'd0, 7'd100);
		send_color(9'd200, 7'd0, 7'd73);
		send_color(9'd511, 7'd0, 7'd127);
		// lightness either side of one half picks the q formula
		send_color(9'd45, 7'd50, 7'd49);
		send_color(9'd45, 7'd50, 7'd50);
		send_color(9'd15, 7'd100, 7'd25);
		send_color(9'd330, 7'd100, 7'd75);
		send_color(9'd90, 7'd100, 7'd100);
		send_color(9'd100, 7'd1, 7'd1);
		send_color(9'd255, 7'd99, 7'd99);

		foreach (phase_idle[i]) begin
			idle_pct = phase_idle[i];
			repeat (463) send_random_color();
		end

		start <= 1'b0;
		@(posedge clk);
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/hsl2rgb_pkg.sv
hdl/hsl2rgb_norm.sv
hdl/hsl2rgb_chan.sv
hdl/hsl_to_rgb_converter_unit.sv
dv/rgb_result_checker.sv
dv/tb_top.sv
